// ===== rtl/core/wps_pkg.sv =====
// Shared types and constants for the weighted prefix-sum sampler.
`default_nettype none

package wps_pkg;

  localparam int DATA_W      = 32;
  localparam int OUT_INDEX_W = 10;
  localparam int OUT_COUNT_W = 11;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // result status codes
  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_SAMPLED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic                     command;
    logic                     restart;
    logic signed [DATA_W-1:0] entry_id;
    logic [DATA_W-1:0]        weight;
    logic [DATA_W-1:0]        random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] picked_id;
    logic [DATA_W-1:0]        picked_weight;
    logic [OUT_INDEX_W-1:0]   picked_index;
    logic [OUT_COUNT_W-1:0]   entry_total;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_RESTART_LOAD,
    OP_SAMPLE
  } op_t;

  // classified command: arg is the masked weight of a load or the fraction of a sample
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] entry_id;
    logic [DATA_W-1:0]        arg;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_SCALE,
    BK_RD,
    BK_CMP,
    BK_GET_CUR,
    BK_GET_PREV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/wps_front.sv =====
// Front stage: takes input transfers, classifies them and hands commands on.
`default_nettype none

module wps_front #(
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire wps_pkg::in_item_t in_data,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output wps_pkg::cmd_t         cmd
);
  import wps_pkg::*;

  localparam int W_EFF = (WEIGHT_BITS < DATA_W) ? WEIGHT_BITS : DATA_W;
  localparam logic [DATA_W-1:0] WMASK = DATA_W'((64'd1 << W_EFF) - 64'd1);

  logic held;
  cmd_t cmd_class;

  assign in_ready  = !held || cmd_ready;
  assign cmd_valid = held;

  always_comb begin
    cmd_class.entry_id = in_data.entry_id;
    if (in_data.command) begin
      cmd_class.op  = OP_SAMPLE;
      cmd_class.arg = in_data.random_fraction;
    end else begin
      cmd_class.op  = in_data.restart ? OP_RESTART_LOAD : OP_LOAD;
      cmd_class.arg = in_data.weight & WMASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (cmd_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_class;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wps_queue.sv =====
// Short command queue decoupling the front stage from the back end.
`default_nettype none

module wps_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire wps_pkg::cmd_t push_data,
  output logic               pop_valid,
  input  wire logic          pop,
  output wps_pkg::cmd_t      pop_data
);
  import wps_pkg::*;

  localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
  localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (fill != FULL_CNT);
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wps_back.sv =====
// Back end: prefix-sum table, fraction scaling, binary search and result register.
`default_nettype none

module wps_back #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire wps_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wps_pkg::out_item_t out_data
);
  import wps_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int W_EFF = (WEIGHT_BITS < DATA_W) ? WEIGHT_BITS : DATA_W;
  localparam int SUM_W = W_EFF + IDX_W;
  localparam int PROD_W = 2 * DATA_W;
  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

  // table
  logic [SUM_W-1:0]  prefix_mem [MAX_ENTRIES];
  logic [DATA_W-1:0] id_mem     [MAX_ENTRIES];
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [SUM_W-1:0]  wr_sum;
  logic [IDX_W-1:0]  rd_addr;
  logic [SUM_W-1:0]  rd_sum;
  logic [DATA_W-1:0] rd_id;

  // control and state
  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  running_total;
  logic              out_load;
  logic              out_free;

  // search datapath
  logic [DATA_W-1:0] frac;
  logic [PROD_W-1:0] prod_lo;
  logic [PROD_W-1:0] prod_hi;
  logic [PROD_W-1:0] total_ext;
  logic [PROD_W-1:0] r_sum;
  logic [SUM_W-1:0]  r;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  mid;
  logic [IDX_W-1:0]  mid_c;
  logic [IDX_W-1:0]  lo_nx;
  logic [IDX_W-1:0]  hi_nx;
  logic [IDX_W-1:0]  lo_m1;
  logic              go_left;
  logic [SUM_W-1:0]  cur_sum;
  logic [DATA_W-1:0] cur_id;
  logic [SUM_W-1:0]  prev_sum;
  logic [SUM_W-1:0]  diff;

  // load datapath
  logic              is_sample;
  logic              empty_table;
  logic [CNT_W-1:0]  count_eff;
  logic [SUM_W-1:0]  total_eff;
  logic              load_full;
  logic [CNT_W-1:0]  count_new;
  logic [CNT_W-1:0]  cnt_m1;
  logic [PROD_W-1:0] wt_ext;

  // output padding
  logic [CNT_W-1:0]              res_count;
  logic [CNT_W+OUT_COUNT_W-1:0]  cnt_pad;
  logic [IDX_W+OUT_INDEX_W-1:0]  idx_pad;
  logic [SUM_W+DATA_W-1:0]       diff_pad;
  out_item_t                     res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      prefix_mem[wr_addr] <= wr_sum;
      id_mem[wr_addr]     <= cmd.entry_id;
    end
    rd_sum <= prefix_mem[rd_addr];
    rd_id  <= id_mem[rd_addr];
  end

  assign out_free    = !out_valid || out_ready;
  assign is_sample   = (cmd.op == OP_SAMPLE);
  assign empty_table = (count == '0) || (running_total == '0);
  assign count_eff   = (cmd.op == OP_RESTART_LOAD) ? '0 : count;
  assign total_eff   = (cmd.op == OP_RESTART_LOAD) ? '0 : running_total;
  assign load_full   = (count_eff == MAX_COUNT);
  assign count_new   = load_full ? count_eff : count_eff + CNT_W'(1);
  assign cnt_m1      = count - CNT_W'(1);
  assign wt_ext      = {{(PROD_W - DATA_W){1'b0}}, cmd.arg};
  assign wr_sum      = total_eff + wt_ext[SUM_W-1:0];
  assign wr_addr     = count_eff[IDX_W-1:0];

  assign total_ext = {{(PROD_W - SUM_W){1'b0}}, running_total};
  assign r_sum     = prod_hi + {{DATA_W{1'b0}}, prod_lo[PROD_W-1:DATA_W]};
  assign mid_c     = lo + ((hi - lo) >> 1);
  assign go_left   = (rd_sum > r);
  assign lo_nx     = go_left ? lo : mid + IDX_W'(1);
  assign hi_nx     = go_left ? mid : hi;
  assign lo_m1     = lo - IDX_W'(1);
  assign prev_sum  = (lo == '0) ? '0 : rd_sum;
  assign diff      = cur_sum - prev_sum;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free && is_sample && !empty_table) begin
          state_next = BK_MUL_LO;
        end
      end
      BK_MUL_LO:   state_next = BK_MUL_HI;
      BK_MUL_HI:   state_next = BK_SCALE;
      BK_SCALE:    state_next = (lo == hi) ? BK_GET_CUR : BK_RD;
      BK_RD:       state_next = BK_CMP;
      BK_CMP:      state_next = (lo_nx == hi_nx) ? BK_GET_CUR : BK_RD;
      BK_GET_CUR:  state_next = BK_GET_PREV;
      BK_GET_PREV: state_next = BK_DONE;
      BK_DONE:     state_next = out_free ? BK_IDLE : BK_DONE;
      default:     state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = lo_m1;
    unique case (state)
      BK_IDLE: begin
        cmd_pop  = cmd_valid && out_free;
        mem_we   = cmd_pop && !is_sample && !load_full;
        out_load = cmd_pop && !(is_sample && !empty_table);
      end
      BK_RD:      rd_addr = mid_c;
      BK_GET_CUR: rd_addr = lo;
      BK_DONE:    out_load = out_free;
      default: begin
        rd_addr = lo_m1;
      end
    endcase
  end

  // result assembly
  always_comb begin
    res        = '0;
    res_count  = count;
    if (state == BK_DONE) begin
      res.status = ST_SAMPLED;
    end else if (is_sample) begin
      res.status = ST_EMPTY;
    end else if (load_full) begin
      res.status = ST_FULL;
      res_count  = count_eff;
    end else begin
      res.status = ST_LOADED;
      res_count  = count_new;
    end
    cnt_pad         = {{OUT_COUNT_W{1'b0}}, res_count};
    idx_pad         = {{OUT_INDEX_W{1'b0}}, lo};
    diff_pad        = {{DATA_W{1'b0}}, diff};
    res.entry_total = cnt_pad[OUT_COUNT_W-1:0];
    if (state == BK_DONE) begin
      res.picked_id     = cur_id;
      res.picked_weight = diff_pad[DATA_W-1:0];
      res.picked_index  = idx_pad[OUT_INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      count         <= '0;
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop && !is_sample) begin
        count <= count_new;
        if (!load_full) begin
          running_total <= wr_sum;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
    if (cmd_pop) begin
      frac <= cmd.arg;
      lo   <= '0;
      hi   <= cnt_m1[IDX_W-1:0];
    end
    case (state)
      BK_MUL_LO:   prod_lo <= PROD_W'(frac) * PROD_W'(total_ext[DATA_W-1:0]);
      BK_MUL_HI:   prod_hi <= PROD_W'(frac) * PROD_W'(total_ext[PROD_W-1:DATA_W]);
      BK_SCALE:    r <= r_sum[SUM_W-1:0];
      BK_RD:       mid <= mid_c;
      BK_CMP: begin
        lo <= lo_nx;
        hi <= hi_nx;
      end
      BK_GET_PREV: begin
        cur_sum <= rd_sum;
        cur_id  <= rd_id;
      end
      default: begin
      end
    endcase
  end

  a_search_only_when_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == BK_MUL_LO) |-> (count != '0 && running_total != '0))
    else $error("search started on an empty or zero-weight table");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RD || state == BK_CMP) |-> (lo < hi))
    else $error("search bounds crossed");

  a_target_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RD) |-> (r < running_total))
    else $error("scaled target not below total weight");

  a_pick_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) |-> ({{(CNT_W - IDX_W + 1){1'b0}}, lo} < {1'b0, count}))
    else $error("picked entry beyond table fill");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_COUNT)
    else $error("entry count exceeds table depth");

endmodule

`default_nettype wire

// ===== rtl/core/weighted_prefix_sum_sampler.sv =====
// Top level of the weighted prefix-sum sampler: front stage, command queue and back end.
`default_nettype none

// Inverse-CDF weighted sampler. A load transfer (command 0) appends an (id, weight)
// entry, storing the id and the running prefix sum of the weights; restart empties
// the table first. A sample transfer (command 1) scales its 0.32 random fraction by
// the total weight, r = floor(fraction * total / 2^32), and binary-searches the prefix
// sums for the first entry whose sum exceeds r, returning its id, weight and index.
// Zero-weight entries are never picked. Status: 0 loaded, 1 sampled, 2 table full
// (load dropped, table unchanged), 3 table empty or total zero. Every transfer in
// yields exactly one transfer out, in order. The front stage registers and classifies
// each transfer, and a two-deep queue feeds the back end, so input is still accepted
// while a result waits on out_ready, until the queue and front register fill. In the
// back end a load or a flagged sample is answered from the idle state. A sample scales
// its fraction, runs k <= ceil(log2(entries)) search steps, each one registered read of
// the prefix-sum RAM followed by a compare, then reads the picked entry and the one
// before it. The scaling is two 32x32 multiplies on successive cycles and a final add.
// Table RAMs are not cleared after reset; only entries below the fill count are used.
module weighted_prefix_sum_sampler #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wps_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wps_pkg::out_item_t      out_data
);
  import wps_pkg::*;

  // front stage to queue
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // queue to back end
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  wps_front #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  wps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_data   (head_cmd)
  );

  // table, scaling, search and the output register
  wps_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
